// ===== design/dmbm_pkg.sv =====
// shared types and constants of the display mode best-match block
`timescale 1ns / 1ps
`default_nettype none
package dmbm_pkg;

  localparam int unsigned MAX_MODES = 256;
  localparam int unsigned CNT_W     = $clog2(MAX_MODES + 1);
  localparam int unsigned QDEPTH    = 2;
  localparam int unsigned QPTR_W    = $clog2(QDEPTH);
  localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);

  localparam int unsigned DIM_W   = 16;
  localparam int unsigned PCLK_W  = 22;
  localparam int unsigned DEN_W   = 32;
  localparam int unsigned NUM_W   = 36;
  localparam int unsigned DVD_W   = 38;
  localparam int unsigned DSR_W   = 33;
  localparam int unsigned SH_W    = DSR_W + 15;
  localparam int unsigned SCORE_W = 27;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned CFG_W   = 3;

  localparam logic [15:0] RATE_SCALE = 16'd10000;
  localparam logic [15:0] RATE_MAX   = 16'hFFFF;
  localparam logic [PCLK_W-1:0] PCLK_MAX = 22'h3FFFFF;
  localparam logic [9:0]  SCORE_H_WEIGHT = 10'd1000;
  localparam logic [6:0]  SCORE_C_WEIGHT = 7'd100;
  localparam logic [15:0] FREQ_RESET = 16'd600;

  // x / 10 = (x * DIV10_MAGIC) >> 35, x / 1000 = (x * DIV1000_MAGIC) >> 38, exact on 32 bits
  localparam logic [31:0] DIV10_MAGIC   = 32'hCCCCCCCD;
  localparam logic [31:0] DIV1000_MAGIC = 32'h10624DD3;
  // product / 1000 exceeds the clock range from here on
  localparam logic [44:0] PCLK_SAT_PRODUCT = 45'd4194304000;

  typedef enum logic [CFG_W-1:0] {
    CFG_WANT_WIDTH  = 3'd0,
    CFG_WANT_HEIGHT = 3'd1,
    CFG_WANT_CS     = 3'd2,
    CFG_WANT_FREQ   = 3'd3,
    CFG_STRICT      = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_MATCH    = 2'd0,
    ST_FALLBACK = 2'd1,
    ST_FAIL     = 2'd2
  } status_e;

  typedef struct packed {
    logic [DIM_W-1:0] want_width;
    logic [DIM_W-1:0] want_height;
    logic [DIM_W-1:0] want_cs;
    logic [DIM_W-1:0] want_freq;
    logic             strict;
  } cfg_t;

  typedef struct packed {
    logic [DIM_W-1:0]  vis_lines;
    logic [PCLK_W-1:0] pclk;
    logic [DEN_W-1:0]  den;
    logic [DIM_W-1:0]  cspace;
    logic [IDX_W-1:0]  index;
    logic              active;
    logic              first;
    logic              wmatch;
    logic              last;
  } entry_t;

  typedef struct packed {
    status_e            status;
    logic [IDX_W-1:0]   index;
    logic [PCLK_W-1:0]  pclk;
    logic               adjusted;
    logic [SCORE_W-1:0] score;
  } result_t;

endpackage
`default_nettype wire

// ===== design/dmbm_front.sv =====
// front end: accepts modes, numbers them and classifies them for the back end
`timescale 1ns / 1ps
`default_nettype none
module dmbm_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push_i,
  input  wire logic                        q_full_i,
  input  wire logic [dmbm_pkg::DIM_W-1:0]  want_width_i,
  input  wire logic [15:0]                 mode_width_i,
  input  wire logic [15:0]                 mode_vis_lines_i,
  input  wire logic [21:0]                 mode_pixel_clock_i,
  input  wire logic [15:0]                 mode_h_total_i,
  input  wire logic [15:0]                 mode_v_total_i,
  input  wire logic [15:0]                 mode_cspace_i,
  input  wire logic                        last_mode_i,
  output logic                             q_push_o,
  output dmbm_pkg::entry_t                 q_data_o
);

  logic [dmbm_pkg::CNT_W-1:0] count_q, count_d;
  logic                       active;

  assign active   = count_q < dmbm_pkg::CNT_W'(dmbm_pkg::MAX_MODES);
  assign q_push_o = push_i && !q_full_i;

  always_comb begin
    q_data_o.vis_lines   = mode_vis_lines_i;
    q_data_o.pclk        = mode_pixel_clock_i;
    q_data_o.den         = dmbm_pkg::DEN_W'(mode_h_total_i) * dmbm_pkg::DEN_W'(mode_v_total_i);
    q_data_o.cspace      = mode_cspace_i;
    q_data_o.index       = count_q[dmbm_pkg::IDX_W-1:0];
    q_data_o.active      = active;
    q_data_o.first       = count_q == '0;
    q_data_o.wmatch      = mode_width_i == want_width_i;
    q_data_o.last        = last_mode_i;
  end

  always_comb begin
    count_d = count_q;
    if (q_push_o) begin
      if (last_mode_i) begin
        count_d = '0;
      end else if (active) begin
        count_d = count_q + dmbm_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule
`default_nettype wire

// ===== design/dmbm_queue.sv =====
// two-entry queue between the front end and the back end
`timescale 1ns / 1ps
`default_nettype none
module dmbm_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire dmbm_pkg::entry_t wdata_i,
  input  wire logic             pop_i,
  output dmbm_pkg::entry_t      rdata_o,
  output logic                  full_o,
  output logic                  empty_o
);

  dmbm_pkg::entry_t                mem_q [dmbm_pkg::QDEPTH];
  logic [dmbm_pkg::QPTR_W-1:0]     wptr_q, rptr_q;
  logic [dmbm_pkg::QCNT_W-1:0]     cnt_q;

  assign full_o  = cnt_q == dmbm_pkg::QCNT_W'(dmbm_pkg::QDEPTH);
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + dmbm_pkg::QPTR_W'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + dmbm_pkg::QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + dmbm_pkg::QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - dmbm_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

// ===== design/dmbm_back.sv =====
// back end: rate divider, scoring, best tracking, clock adjust and result register
`timescale 1ns / 1ps
`default_nettype none
module dmbm_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dmbm_pkg::cfg_t    cfg_i,
  input  wire dmbm_pkg::entry_t  q_data_i,
  input  wire logic              q_empty_i,
  output logic                   q_pop_o,
  input  wire logic              pop_i,
  output logic                   out_valid_o,
  output dmbm_pkg::result_t      out_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_PREP, S_DIV, S_SCORE, S_UPD, S_SEL, S_ADJ1, S_ADJ2, S_ADJ3, S_EMIT
  } state_e;

  state_e                                state_q;
  dmbm_pkg::entry_t                      cur_q;
  logic [dmbm_pkg::NUM_W-1:0]            num_q;
  logic [dmbm_pkg::DVD_W-1:0]            rem_q;
  logic [dmbm_pkg::SH_W-1:0]             dsh_q;
  logic [3:0]                            bit_q;
  logic [15:0]                           quo_q;
  logic [15:0]                           freq_q;
  logic [dmbm_pkg::SCORE_W-1:0]          score_q;
  logic                                  have_best_q;
  logic [dmbm_pkg::SCORE_W-1:0]          best_score_q;
  logic [dmbm_pkg::IDX_W-1:0]            best_index_q;
  logic [dmbm_pkg::DEN_W-1:0]            best_den_q, first_den_q, sel_den_q;
  logic [dmbm_pkg::PCLK_W-1:0]           best_pclk_q, first_pclk_q;
  logic [15:0]                           best_freq_q, first_freq_q;
  logic [28:0]                           c1_q;
  logic [44:0]                           c2_q;
  dmbm_pkg::result_t                     res_q;
  logic                                  out_valid_q;
  dmbm_pkg::result_t                     out_q;

  logic [dmbm_pkg::DVD_W-1:0]  dvd;
  logic [dmbm_pkg::DSR_W-1:0]  dsr;
  logic                        rate_sat;
  logic                        trial_ge;
  logic [15:0]                 quo_n;
  logic [15:0]                 dv, df, dc;
  logic [dmbm_pkg::SCORE_W-1:0] score_n;
  logic [63:0]                 div10_p, div1000_p;
  logic                        use_best, sel_adjust;
  logic [dmbm_pkg::DEN_W-1:0]  sel_den;
  logic [dmbm_pkg::PCLK_W-1:0] sel_pclk;
  logic [15:0]                 sel_freq;

  assign q_pop_o     = (state_q == S_IDLE) && !q_empty_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // rounded rate: (2*num + den) / (2*den)
  always_comb begin
    dvd      = {num_q, 1'b0} + dmbm_pkg::DVD_W'(cur_q.den);
    dsr      = {cur_q.den, 1'b0};
    rate_sat = (dmbm_pkg::DSR_W + 16)'(dvd) >= {dsr, 16'b0};
    trial_ge = dmbm_pkg::SH_W'(rem_q) >= dsh_q;
    quo_n    = {quo_q[14:0], trial_ge};
  end

  always_comb begin
    dv = (cur_q.vis_lines >= cfg_i.want_height) ? cur_q.vis_lines - cfg_i.want_height
                                                 : cfg_i.want_height - cur_q.vis_lines;
    df = (freq_q >= cfg_i.want_freq) ? freq_q - cfg_i.want_freq : cfg_i.want_freq - freq_q;
    dc = (cur_q.cspace >= cfg_i.want_cs) ? cur_q.cspace - cfg_i.want_cs
                                         : cfg_i.want_cs - cur_q.cspace;
    score_n = dmbm_pkg::SCORE_W'(dv) * dmbm_pkg::SCORE_W'(dmbm_pkg::SCORE_H_WEIGHT)
            + dmbm_pkg::SCORE_W'(df)
            + dmbm_pkg::SCORE_W'(dc) * dmbm_pkg::SCORE_W'(dmbm_pkg::SCORE_C_WEIGHT);
  end

  always_comb begin
    use_best   = have_best_q;
    sel_den    = use_best ? best_den_q  : first_den_q;
    sel_pclk   = use_best ? best_pclk_q : first_pclk_q;
    sel_freq   = use_best ? best_freq_q : first_freq_q;
    sel_adjust = sel_freq != cfg_i.want_freq;
    div10_p    = 64'(sel_den_q) * 64'(dmbm_pkg::DIV10_MAGIC);
    div1000_p  = 64'(c2_q[31:0]) * 64'(dmbm_pkg::DIV1000_MAGIC);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cur_q        <= '0;
      num_q        <= '0;
      rem_q        <= '0;
      dsh_q        <= '0;
      bit_q        <= '0;
      quo_q        <= '0;
      freq_q       <= '0;
      score_q      <= '0;
      have_best_q  <= 1'b0;
      best_score_q <= '0;
      best_index_q <= '0;
      best_den_q   <= '0;
      best_pclk_q  <= '0;
      best_freq_q  <= '0;
      first_den_q  <= '0;
      first_pclk_q <= '0;
      first_freq_q <= '0;
      sel_den_q    <= '0;
      c1_q         <= '0;
      c2_q         <= '0;
      res_q        <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      if (pop_i && out_valid_q && state_q != S_EMIT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (!q_empty_i) begin
            cur_q <= q_data_i;
            if (q_data_i.active) begin
              state_q <= S_MUL;
            end else if (q_data_i.last) begin
              state_q <= S_SEL;
            end
          end
        end
        S_MUL: begin
          num_q   <= dmbm_pkg::NUM_W'(cur_q.pclk) * dmbm_pkg::NUM_W'(dmbm_pkg::RATE_SCALE);
          state_q <= S_PREP;
        end
        S_PREP: begin
          if (cur_q.den == '0) begin
            freq_q  <= '0;
            state_q <= S_SCORE;
          end else if (rate_sat) begin
            freq_q  <= dmbm_pkg::RATE_MAX;
            state_q <= S_SCORE;
          end else begin
            rem_q   <= dvd;
            dsh_q   <= {dsr, 15'b0};
            bit_q   <= 4'd15;
            quo_q   <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (trial_ge) begin
            rem_q <= rem_q - dsh_q[dmbm_pkg::DVD_W-1:0];
          end
          quo_q <= quo_n;
          dsh_q <= dsh_q >> 1;
          bit_q <= bit_q - 4'd1;
          if (bit_q == '0) begin
            freq_q  <= quo_n;
            state_q <= S_SCORE;
          end
        end
        S_SCORE: begin
          if (cur_q.first) begin
            first_den_q  <= cur_q.den;
            first_pclk_q <= cur_q.pclk;
            first_freq_q <= freq_q;
          end
          score_q <= score_n;
          if (cur_q.wmatch) begin
            state_q <= S_UPD;
          end else if (cur_q.last) begin
            state_q <= S_SEL;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_UPD: begin
          if (!have_best_q || score_q < best_score_q) begin
            have_best_q  <= 1'b1;
            best_score_q <= score_q;
            best_index_q <= cur_q.index;
            best_den_q   <= cur_q.den;
            best_pclk_q  <= cur_q.pclk;
            best_freq_q  <= freq_q;
          end
          state_q <= cur_q.last ? S_SEL : S_IDLE;
        end
        S_SEL: begin
          sel_den_q <= sel_den;
          if (!use_best && cfg_i.strict) begin
            res_q   <= '{status: dmbm_pkg::ST_FAIL, index: '0, pclk: '0, adjusted: 1'b0,
                         score: '0};
            state_q <= S_EMIT;
          end else begin
            res_q.status   <= use_best ? dmbm_pkg::ST_MATCH : dmbm_pkg::ST_FALLBACK;
            res_q.index    <= use_best ? best_index_q : '0;
            res_q.score    <= use_best ? best_score_q : '0;
            res_q.pclk     <= sel_pclk;
            res_q.adjusted <= sel_adjust;
            state_q        <= sel_adjust ? S_ADJ1 : S_EMIT;
          end
          have_best_q  <= 1'b0;
          best_score_q <= '0;
          best_index_q <= '0;
        end
        S_ADJ1: begin
          c1_q    <= div10_p[63:35];
          state_q <= S_ADJ2;
        end
        S_ADJ2: begin
          c2_q    <= 45'(c1_q) * 45'(cfg_i.want_freq);
          state_q <= S_ADJ3;
        end
        S_ADJ3: begin
          res_q.pclk <= (c2_q >= dmbm_pkg::PCLK_SAT_PRODUCT) ? dmbm_pkg::PCLK_MAX
                                                             : div1000_p[59:38];
          state_q    <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_q || pop_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/display_mode_best_match.sv =====
// top level of the display mode best-match block
`timescale 1ns / 1ps
`default_nettype none
// Scores a list of display modes against a wanted width, height, colour space and
// refresh rate, and gives one result per list when the mode marked last_mode has been
// taken in. The front end takes a mode whenever full_o is low and queues it; the back
// end works on one mode at a time: it fetches the mode, forms pclk*10000, sets up the
// rate division, runs the restoring divider for the 16 quotient bits, scores the mode
// and, for a mode of the wanted width, updates the best mode (the divider is skipped
// when h_total*v_total is 0 or the rate saturates; modes past the 256th are only
// fetched). After the last mode it picks and adjusts the clock and loads the result
// register, waiting while the previous result waits for pop_i.
// Configuration must be written through cfg_we_i/cfg_idx_i/cfg_wdata_i only while no
// list is in progress; the block itself does not enforce this.
module display_mode_best_match (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        push_i,
  output logic             full_o,
  input  wire logic [15:0] mode_width_i,
  input  wire logic [15:0] mode_vis_lines_i,
  input  wire logic [21:0] mode_pixel_clock_i,
  input  wire logic [15:0] mode_h_total_i,
  input  wire logic [15:0] mode_v_total_i,
  input  wire logic [15:0] mode_cspace_i,
  input  wire logic        last_mode_i,
  output logic             empty_o,
  input  wire logic        pop_i,
  output logic [1:0]       status_o,
  output logic [7:0]       mode_index_o,
  output logic [21:0]      pixel_clock_out_o,
  output logic             adjusted_o,
  output logic [26:0]      best_score_o
);

  dmbm_pkg::cfg_t    cfg_q;
  dmbm_pkg::entry_t  q_wdata, q_rdata;
  dmbm_pkg::result_t res;
  logic              q_push, q_pop, q_full, q_empty, out_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.want_width  <= '0;
      cfg_q.want_height <= '0;
      cfg_q.want_cs     <= '0;
      cfg_q.want_freq   <= dmbm_pkg::FREQ_RESET;
      cfg_q.strict      <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dmbm_pkg::CFG_WANT_WIDTH:  cfg_q.want_width  <= cfg_wdata_i;
        dmbm_pkg::CFG_WANT_HEIGHT: cfg_q.want_height <= cfg_wdata_i;
        dmbm_pkg::CFG_WANT_CS:     cfg_q.want_cs     <= cfg_wdata_i;
        dmbm_pkg::CFG_WANT_FREQ:   cfg_q.want_freq   <= cfg_wdata_i;
        dmbm_pkg::CFG_STRICT:      cfg_q.strict      <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  dmbm_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push_i             (push_i),
    .q_full_i           (q_full),
    .want_width_i       (cfg_q.want_width),
    .mode_width_i       (mode_width_i),
    .mode_vis_lines_i   (mode_vis_lines_i),
    .mode_pixel_clock_i (mode_pixel_clock_i),
    .mode_h_total_i     (mode_h_total_i),
    .mode_v_total_i     (mode_v_total_i),
    .mode_cspace_i      (mode_cspace_i),
    .last_mode_i        (last_mode_i),
    .q_push_o           (q_push),
    .q_data_o           (q_wdata)
  );

  dmbm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  dmbm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_data_i    (q_rdata),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .pop_i       (pop_i),
    .out_valid_o (out_valid),
    .out_o       (res)
  );

  assign full_o            = q_full;
  assign empty_o           = !out_valid;
  assign status_o          = res.status;
  assign mode_index_o      = res.index;
  assign pixel_clock_out_o = res.pclk;
  assign adjusted_o        = res.adjusted;
  assign best_score_o      = res.score;

  // strict failure carries no mode
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && status_o == dmbm_pkg::ST_FAIL |->
      mode_index_o == '0 && pixel_clock_out_o == '0 && !adjusted_o && best_score_o == '0)
    else $error("strict failure result has nonzero fields");

  // fallback reports the first mode with no score
  a_fallback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && status_o == dmbm_pkg::ST_FALLBACK |-> mode_index_o == '0 && best_score_o == '0)
    else $error("fallback result has index or score");

  // queue pop only while the back end has taken something real
  a_queue_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

endmodule
`default_nettype wire
